### src/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg - shared constants for the linear prime sieve
// Field widths and register reset values used by the sieve engine.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int FIELD_W = 17;                    // width of the payload fields
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 17'h10000;
  localparam int CFG_MAX = (1 << FIELD_W) - 1;    // largest value the limit can hold

endpackage

### src/linear_prime_sieve.sv
// ----------------------------------------------------------------------------
// linear_prime_sieve - linear sieve engine for smallest prime factors
// Walks the numbers 2..limit, one per input beat, and reports each number's
// smallest prime factor from a factor store built on the fly.
// ----------------------------------------------------------------------------
// Each accepted beat processes one number: the factor store is read for it,
// a new prime goes into the prime list, and then the list is walked, each
// listed prime p marking number*p in the store. A sequencer drives both
// RAMs; each walk step is a list read, a multiply and a store write. A
// beat past the limit gives no result. The store needs no per-entry
// valid bits: the engine remembers the highest entry it has written, and a
// restart first zeroes entries 0 up to that mark, one per cycle. After
// reset the whole store (MAX_LIMIT+1 entries, capped at 2^17) is swept
// the same way before the first beat is taken; configuration writes are
// accepted at any time during the sweep.
// ----------------------------------------------------------------------------
module linear_prime_sieve
  import lps_pkg::*;
#(
  parameter int MAX_LIMIT   = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_number,
  output logic [FIELD_W-1:0] out_smallest_factor,
  output logic               out_is_prime,
  output logic               out_last
);

  // the limit register caps what the store can ever be asked for
  localparam int EFF_MAX  = (MAX_LIMIT < CFG_MAX) ? MAX_LIMIT : CFG_MAX;
  localparam int NUM_W    = $clog2(EFF_MAX + 2);
  localparam int FS_DEPTH = EFF_MAX + 1;
  localparam int FS_AW    = $clog2(FS_DEPTH);
  localparam int PL_AW    = $clog2(PRIME_SLOTS);
  localparam int PC_W     = $clog2(PRIME_SLOTS + 1);
  localparam int PROD_W   = 2 * NUM_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_READ, S_LOOK, S_MUL, S_MARK, S_EMIT
  } state_t;

  state_t             state_r;
  logic [FIELD_W-1:0] limit_r;
  logic [NUM_W-1:0]   cur_r;
  logic [NUM_W-1:0]   spf_r;
  logic               prime_r;
  logic [NUM_W-1:0]   p_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PC_W-1:0]    pcount_r;
  logic [PC_W-1:0]    j_r;
  logic [FS_AW-1:0]   hw_r;
  logic [FS_AW-1:0]   clr_addr_r;
  logic               clr_run_r;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_number_r;
  logic [FIELD_W-1:0] out_factor_r;
  logic               out_is_prime_r;
  logic               out_last_r;

  logic [NUM_W-1:0]   lim;
  logic               run_ok;
  logic               fs_is_zero;
  logic               over;
  logic [FS_AW-1:0]   prod_a;
  logic [FS_AW-1:0]   cur_a;

  logic               fs_we, fs_re;
  logic [FS_AW-1:0]   fs_waddr;
  logic [NUM_W-1:0]   fs_wdata, fs_rdata;
  logic               pl_we, pl_re;
  logic [PL_AW-1:0]   pl_waddr, pl_raddr;
  logic [NUM_W-1:0]   pl_rdata;

  assign lim = NUM_W'((limit_r > FIELD_W'(EFF_MAX)) ? FIELD_W'(EFF_MAX) : limit_r);
  assign run_ok     = (lim >= NUM_W'(2)) && (cur_r <= lim);
  assign fs_is_zero = (fs_rdata == '0);
  assign over       = (prod_r > PROD_W'(lim));
  assign prod_a     = prod_r[FS_AW-1:0];
  assign cur_a      = cur_r[FS_AW-1:0];

  // memory port control
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = clr_addr_r;
    fs_wdata = '0;
    fs_re    = (state_r == S_START) && run_ok;
    pl_we    = 1'b0;
    pl_re    = (state_r == S_LOOK) && (j_r < pcount_r);
    case (state_r)
      S_CLEAR: begin
        fs_we = 1'b1;
      end
      S_READ: begin
        fs_we    = fs_is_zero;
        fs_waddr = cur_a;
        fs_wdata = cur_r;
        pl_we    = fs_is_zero && (pcount_r < PC_W'(PRIME_SLOTS));
      end
      S_MARK: begin
        fs_we    = !over;
        fs_waddr = prod_a;
        fs_wdata = p_r;
      end
      default: begin
      end
    endcase
  end

  assign pl_waddr = pcount_r[PL_AW-1:0];
  assign pl_raddr = j_r[PL_AW-1:0];

  lps_mem #(.DEPTH(FS_DEPTH), .DATA_W(NUM_W)) u_factor_store (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (cur_a),
    .rdata (fs_rdata)
  );

  lps_mem #(.DEPTH(PRIME_SLOTS), .DATA_W(NUM_W)) u_prime_list (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (cur_r),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      limit_r     <= LIMIT_RESET;
      cur_r       <= NUM_W'(2);
      pcount_r    <= '0;
      j_r         <= '0;
      hw_r        <= FS_AW'(FS_DEPTH - 1);
      clr_addr_r  <= '0;
      clr_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // S_EMIT owns the output register while it loads a new beat
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == hw_r) begin
            hw_r    <= '0;
            state_r <= clr_run_r ? S_START : S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + FS_AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              cur_r      <= NUM_W'(2);
              pcount_r   <= '0;
              clr_addr_r <= '0;
              clr_run_r  <= 1'b1;
              state_r    <= S_CLEAR;
            end else begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          state_r <= run_ok ? S_READ : S_IDLE;
        end
        S_READ: begin
          prime_r <= fs_is_zero;
          spf_r   <= fs_is_zero ? cur_r : fs_rdata;
          j_r     <= '0;
          if (fs_is_zero) begin
            if (cur_a > hw_r) begin
              hw_r <= cur_a;
            end
            if (pcount_r < PC_W'(PRIME_SLOTS)) begin
              pcount_r <= pcount_r + PC_W'(1);
            end
          end
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          state_r <= (j_r < pcount_r) ? S_MUL : S_EMIT;
        end
        S_MUL: begin
          p_r     <= pl_rdata;
          prod_r  <= PROD_W'(cur_r) * PROD_W'(pl_rdata);
          state_r <= S_MARK;
        end
        S_MARK: begin
          if (over) begin
            state_r <= S_EMIT;
          end else begin
            if (prod_a > hw_r) begin
              hw_r <= prod_a;
            end
            if (p_r == spf_r) begin
              state_r <= S_EMIT;
            end else begin
              j_r     <= j_r + PC_W'(1);
              state_r <= S_LOOK;
            end
          end
        end
        S_EMIT: begin
          // wait for the output slot to free up
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_number_r   <= FIELD_W'(cur_r);
            out_factor_r   <= FIELD_W'(spf_r);
            out_is_prime_r <= prime_r;
            out_last_r     <= (cur_r == lim);
            cur_r          <= cur_r + NUM_W'(1);
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_number          = out_number_r;
  assign out_smallest_factor = out_factor_r;
  assign out_is_prime        = out_is_prime_r;
  assign out_last            = out_last_r;

endmodule

### src/lps_mem.sv
// ----------------------------------------------------------------------------
// lps_mem - simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lps_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 17,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### test/linear_prime_sieve_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_prime_sieve_test - self-checking testbench for the linear prime sieve
// Sends restart/advance beats in random bursts while the result side stalls,
// and checks every result beat against a behavioral sieve that tracks the
// accepted beats. Uses a small build (MAX_LIMIT 512, 64 prime slots), so full
// sweeps, limit saturation and a full prime list all fit in one run.
// ----------------------------------------------------------------------------
module linear_prime_sieve_test;
  import lps_pkg::*;

  localparam int SIEVE_MAX      = 512;
  localparam int LIST_SLOTS     = 64;
  localparam int SETTLE_CYCLES  = 800;    // store clear plus the longest prime walk
  localparam int RANDOM_NUMBERS = 1200;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_PRINTS     = 100;

  typedef struct {
    logic [FIELD_W-1:0] number;
    logic [FIELD_W-1:0] smallest_factor;
    logic               is_prime;
    logic               last;
  } sieve_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_number;
  logic [FIELD_W-1:0] out_smallest_factor;
  logic               out_is_prime;
  logic               out_last;

  // behavioral sieve
  logic [FIELD_W-1:0] factor_of [0:SIEVE_MAX];
  logic [FIELD_W-1:0] known_primes [0:LIST_SLOTS-1];
  int unsigned        primes_known;
  int unsigned        next_number;
  int unsigned        marked_top;
  int unsigned        numbers_predicted = 0;
  logic [FIELD_W-1:0] limit_reg;
  sieve_result_t      expected_numbers [$];

  int errors = 0;

  // traffic shaping
  int burst_left   = 0;
  int gap_max      = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int hold_left    = 0;

  linear_prime_sieve #(
    .MAX_LIMIT  (SIEVE_MAX),
    .PRIME_SLOTS(LIST_SLOTS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_number         (out_number),
    .out_smallest_factor(out_smallest_factor),
    .out_is_prime       (out_is_prime),
    .out_last           (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  task automatic clear_sieve_model();
    for (int k = 0; k <= marked_top; k++) begin
      factor_of[k] = '0;
    end
    primes_known = 0;
    next_number  = 2;
    marked_top   = 0;
  endtask

  function automatic int unsigned active_limit();
    return (limit_reg > SIEVE_MAX) ? SIEVE_MAX : limit_reg;
  endfunction

  // One accepted beat: advance the sieve by one number, queue its result.
  task automatic sieve_advance(bit restart);
    int unsigned   lim;
    int unsigned   num;
    int unsigned   spf;
    int unsigned   p;
    int unsigned   prod;
    int unsigned   j;
    bit            prime;
    sieve_result_t r;
    if (restart) begin
      clear_sieve_model();
    end
    lim = active_limit();
    num = next_number;
    if (lim < 2 || num > lim) begin
      return;
    end
    spf   = factor_of[num];
    prime = (spf == 0);
    if (prime) begin
      spf = num;
      factor_of[num] = FIELD_W'(num);
      if (num > marked_top) marked_top = num;
      // a full list still reports the prime, it just isn't stored
      if (primes_known < LIST_SLOTS) begin
        known_primes[primes_known] = FIELD_W'(num);
        primes_known++;
      end
    end
    for (j = 0; j < primes_known; j++) begin
      p    = known_primes[j];
      prod = num * p;
      if (prod > lim) break;
      factor_of[prod] = FIELD_W'(p);
      if (prod > marked_top) marked_top = prod;
      if (p == spf) break;
    end
    r.number          = FIELD_W'(num);
    r.smallest_factor = FIELD_W'(spf);
    r.is_prime        = prime;
    r.last            = (num == lim);
    expected_numbers.push_back(r);
    numbers_predicted++;
    next_number = num + 1;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sieve_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, number %0d", out_number));
      end else begin
        want = expected_numbers.pop_front();
        if (out_number !== want.number)
          report_mismatch($sformatf("number %0d, expected %0d", out_number, want.number));
        if (out_smallest_factor !== want.smallest_factor)
          report_mismatch($sformatf("number %0d: factor %0d, expected %0d", want.number,
                                    out_smallest_factor, want.smallest_factor));
        if (out_is_prime !== want.is_prime)
          report_mismatch($sformatf("number %0d: is_prime %0b, expected %0b", want.number,
                                    out_is_prime, want.is_prime));
        if (out_last !== want.last)
          report_mismatch($sformatf("number %0d: last %0b, expected %0b", want.number,
                                    out_last, want.last));
      end
    end
  end

  task automatic send_beat(bit restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sieve_advance(restart);
  endtask

  // Sender pause: drop valid and wait for every expected result.
  task automatic wait_drain(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  // Reset limit saturates to the build's maximum; 2..7 covers primes and composites.
  task automatic test_opening_numbers();
    gap_max   = 0;
    stall_pct = 0;
    repeat (6) send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
  endtask

  // Smallest limit, then limits that allow no number at all.
  task automatic test_limit_edges();
    stall_pct = 30;
    write_limit(2);
    send_beat(1'b1);
    send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
    write_limit(0);
    send_beat(1'b1);
    send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
    write_limit(1);
    send_beat(1'b1);
    wait_drain(SETTLE_CYCLES);
  endtask

  // Limit changes without restart; 10 was skipped under limit 6 and stays unmarked.
  task automatic test_limit_moves();
    write_limit(FIELD_W'(CFG_MAX));
    repeat (3) send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
    write_limit(6);
    repeat (4) send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
    write_limit(12);
    repeat (4) send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
  endtask

  // Receiver holds off while the sender keeps offering beats back to back.
  task automatic test_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    write_limit(200);
    send_beat(1'b1);
    hold_request = HOLD_CYCLES;
    repeat (59) send_beat(1'b0);
    wait_drain(SETTLE_CYCLES);
  endtask

  task automatic test_random_runs();
    int unsigned start_count;
    int unsigned lim_val;
    int unsigned eff;
    int unsigned first_num;
    int          count;
    int          phase;
    bit          restart_first;
    start_count = numbers_predicted;
    phase = 0;
    while (numbers_predicted - start_count < RANDOM_NUMBERS) begin
      if (phase == 1) begin
        lim_val = $urandom_range(SIEVE_MAX, CFG_MAX);        // saturating full sweep
      end else if (phase == 3) begin
        lim_val = $urandom_range(320, SIEVE_MAX - 1);        // fills the prime list
      end else begin
        case ($urandom_range(0, 9))
          0:       lim_val = $urandom_range(0, 1);
          1:       lim_val = $urandom_range(2, 8);
          default: lim_val = $urandom_range(9, 150);
        endcase
      end
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
      write_limit(FIELD_W'(lim_val));
      eff = (lim_val > SIEVE_MAX) ? SIEVE_MAX : lim_val;
      restart_first = !(phase > 0 && phase != 1 && phase != 3 && $urandom_range(0, 4) == 0);
      first_num = restart_first ? 2 : next_number;
      count = (eff >= first_num) ? eff - first_num + 1 : 0;
      count += $urandom_range(1, 3);                         // a few beats past the limit
      for (int k = 0; k < count; k++) begin
        send_beat((k == 0 && restart_first) || $urandom_range(0, 299) == 0);
      end
      wait_drain(SETTLE_CYCLES);
      phase++;
    end
  endtask

  initial begin : run_tests
    for (int k = 0; k <= SIEVE_MAX; k++) begin
      factor_of[k] = '0;
    end
    marked_top = 0;
    limit_reg  = LIMIT_RESET;
    clear_sieve_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_opening_numbers();
    test_limit_edges();
    test_limit_moves();
    test_backpressure();
    test_random_runs();
    wait_drain(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
src/lps_pkg.sv
src/lps_mem.sv
src/linear_prime_sieve.sv
test/linear_prime_sieve_test.sv
